>>> sv/overwrite_ring_batch_pop_unit_defines.svh
// assertion macros for the overwrite ring batch pop unit
// needs a clock named clk and a synchronous reset named rst in the including module
`ifndef OVERWRITE_RING_BATCH_POP_UNIT_DEFINES_SVH
`define OVERWRITE_RING_BATCH_POP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define ORBP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("orbp assertion failed");

// checked during reset as well
`define ORBP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("orbp reset assertion failed");

`else

`define ORBP_ASSERT(label, prop)
`define ORBP_ASSERT_RST(label, prop)

`endif

`endif

>>> sv/orbp_pkg.sv
// shared types and constants of the overwrite ring batch pop unit
// no dependencies
package orbp_pkg;

  localparam int unsigned DEPTH_DEF = 512;
  localparam int unsigned BATCH_DEF = 16;
  localparam int unsigned FILL_W    = 10;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        stamp_usec;
    logic [31:0]        edge_count;
    logic [23:0]        conv_status;
    logic signed [23:0] chan1_sample;
    logic signed [23:0] chan2_sample;
    logic signed [31:0] chan2_filtered;
    logic [31:0]        sequence_number;
  } req_t;

  // one stored sample record
  typedef struct packed {
    logic [63:0]        stamp_usec;
    logic [31:0]        edge_count;
    logic [23:0]        conv_status;
    logic signed [23:0] chan1_sample;
    logic signed [23:0] chan2_sample;
    logic signed [31:0] chan2_filtered;
    logic [31:0]        sequence_number;
  } rec_t;

  typedef struct packed {
    logic [63:0]        out_stamp_usec;
    logic [31:0]        out_edge_count;
    logic [23:0]        out_conv_status;
    logic signed [23:0] out_chan1_sample;
    logic signed [23:0] out_chan2_sample;
    logic signed [31:0] out_chan2_filtered;
    logic [31:0]        out_sequence_number;
    logic               record_valid;
    logic               last_of_run;
    logic               batch_avail;
    logic [FILL_W-1:0]  fill_level;
    logic [31:0]        overflow_total;
  } res_t;

endpackage

>>> sv/overwrite_ring_batch_pop_unit.sv
// overwrite ring batch pop unit: ring of sample records in one synchronous memory
// depends on orbp_pkg and overwrite_ring_batch_pop_unit_defines.svh
//
// Ring of DEPTH sample records held in a single-port-write, single-port-read
// memory with a registered read port. A push request writes one record and,
// when the ring is full, drops the oldest record and bumps the wrapping
// overflow count; it answers with one status result. A flush empties the
// ring (overflow count kept) and answers with one status result. A pop
// request with at least BATCH records held streams BATCH records oldest first,
// one per cycle when the result side does not stall, the last one flagged
// last_of_run; each record passes the memory read stage, then the output
// register. The request side stalls until the last record of the batch has
// entered the output register. A pop with fewer records answers with one
// status result and removes nothing. Push, flush and short pop requests may
// follow back to back while the output register keeps up. No request is
// taken while a batch streams out, so reads and writes never touch the same
// entry in one cycle. Every result carries batch_avail, fill_level and
// overflow_total as they stand after the request. Memory contents are not
// cleared by reset; a pop only ever reads entries written by earlier pushes.
`include "overwrite_ring_batch_pop_unit_defines.svh"

module overwrite_ring_batch_pop_unit #(
  parameter int unsigned DEPTH = orbp_pkg::DEPTH_DEF,
  parameter int unsigned BATCH = orbp_pkg::BATCH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  orbp_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output orbp_pkg::res_t res
);
  import orbp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned REM_W = $clog2(BATCH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // ring pointers and counters
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [31:0]      drop_count, drop_count_next;

  // batch sequencer
  logic             busy, busy_next;
  logic [REM_W-1:0] rem, rem_next;

  // memory read stage
  rec_t             rd_data;
  logic             rd_valid, rd_valid_next;
  logic             rd_last;

  // output register
  res_t             res_next;
  logic             res_valid_next;

  logic             req_accept;
  logic             out_free;
  logic             rd_move;
  logic             rd_issue;
  logic             batch_ok;
  logic             wr_en;
  logic             load_status;
  rec_t             wr_rec;

  rec_t             mem [DEPTH];

  // handshake
  assign out_free   = !res_valid || !res_stall;
  assign req_stall  = busy || !out_free;
  assign req_accept = req_valid && !req_stall;

  // read stage hands its record on whenever the output register frees up
  assign rd_move  = rd_valid && out_free;
  // next memory read only when the read stage is empty or emptying
  assign rd_issue = busy && (rem != '0) && (!rd_valid || rd_move);
  assign batch_ok = 32'(held_count) >= 32'(BATCH);

  assign wr_rec.stamp_usec      = req.stamp_usec;
  assign wr_rec.edge_count      = req.edge_count;
  assign wr_rec.conv_status     = req.conv_status;
  assign wr_rec.chan1_sample    = req.chan1_sample;
  assign wr_rec.chan2_sample    = req.chan2_sample;
  assign wr_rec.chan2_filtered  = req.chan2_filtered;
  assign wr_rec.sequence_number = req.sequence_number;

  // request decode and pointer bookkeeping
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    held_count_next    = held_count;
    drop_count_next    = drop_count;
    busy_next          = busy;
    rem_next           = rem;
    wr_en              = 1'b0;
    load_status        = 1'b0;

    if (req_accept) begin
      load_status = 1'b1;
      unique case (req.operation)
        OP_PUSH: begin
          wr_en              = 1'b1;
          write_pointer_next = next_slot(write_pointer);
          if (held_count == CNT_FULL) begin
            // full ring: oldest record goes, count stays at DEPTH
            read_pointer_next = next_slot(read_pointer);
            drop_count_next   = drop_count + 32'd1;
          end else begin
            held_count_next = held_count + 1'b1;
          end
        end
        OP_FLUSH: begin
          read_pointer_next = write_pointer;
          held_count_next   = '0;
        end
        OP_POP: begin
          if (batch_ok) begin
            // fill level drops at once, results report the level after the batch
            held_count_next = held_count - CNT_W'(BATCH);
            busy_next       = 1'b1;
            rem_next        = REM_W'(BATCH);
            load_status     = 1'b0;
          end
        end
        default: begin
          // unused code: status only
        end
      endcase
    end

    if (rd_issue) begin
      read_pointer_next = next_slot(read_pointer);
      rem_next          = rem - 1'b1;
    end

    if (rd_move && rd_last) begin
      busy_next = 1'b0;
    end
  end

  // read stage occupancy
  always_comb begin
    rd_valid_next = rd_valid;
    if (rd_issue) begin
      rd_valid_next = 1'b1;
    end else if (rd_move) begin
      rd_valid_next = 1'b0;
    end
  end

  // output register contents
  always_comb begin
    res_next       = res;
    res_valid_next = res_valid;
    if (load_status) begin
      res_next                = '0;
      res_next.last_of_run    = 1'b1;
      res_next.batch_avail    = 32'(held_count_next) >= 32'(BATCH);
      res_next.fill_level     = FILL_W'(held_count_next);
      res_next.overflow_total = drop_count_next;
      res_valid_next          = 1'b1;
    end else if (rd_move) begin
      res_next.out_stamp_usec      = rd_data.stamp_usec;
      res_next.out_edge_count      = rd_data.edge_count;
      res_next.out_conv_status     = rd_data.conv_status;
      res_next.out_chan1_sample    = rd_data.chan1_sample;
      res_next.out_chan2_sample    = rd_data.chan2_sample;
      res_next.out_chan2_filtered  = rd_data.chan2_filtered;
      res_next.out_sequence_number = rd_data.sequence_number;
      res_next.record_valid        = 1'b1;
      res_next.last_of_run         = rd_last;
      // counters already hold their post-batch values
      res_next.batch_avail         = batch_ok;
      res_next.fill_level          = FILL_W'(held_count);
      res_next.overflow_total      = drop_count;
      res_valid_next               = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      held_count    <= '0;
      drop_count    <= '0;
      busy          <= 1'b0;
      rem           <= '0;
      rd_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      held_count    <= held_count_next;
      drop_count    <= drop_count_next;
      busy          <= busy_next;
      rem           <= rem_next;
      rd_valid      <= rd_valid_next;
      res_valid     <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    if (rd_issue) begin
      rd_last <= (rem == REM_ONE);
    end
  end

  // record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pointer] <= wr_rec;
    end
    if (rd_issue) begin
      rd_data <= mem[read_pointer];
    end
  end

  `ORBP_ASSERT_RST(a_reset_idle, rst |=> (!busy && !res_valid && !rd_valid))
  `ORBP_ASSERT(a_held_bounded, 32'(held_count) <= 32'(DEPTH))
  `ORBP_ASSERT(a_busy_stalls, busy |-> req_stall)
  `ORBP_ASSERT(a_rd_in_batch, rd_valid |-> busy)
  `ORBP_ASSERT(a_last_ends_batch, (rd_move && rd_last) |=> !busy)

endmodule
